>>> rtl/core/ptg_pkg.sv
// Shared types and constants for the PWM tone generator with duration.
// Used by ptg_divider, ptg_timer and the top level; depends on nothing.
`default_nettype none

package ptg_pkg;

	// field and register widths
	localparam int FREQ_W     = 16;
	localparam int DUR_W      = 16;
	localparam int REF_W      = 24;
	localparam int PRESC_W    = 17;
	localparam int PCNT_W     = 16;
	localparam int MSDIV_W    = 25;
	localparam int MSCNT_W    = 24;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 25;
	localparam int S_DATA_W   = 32;
	localparam int M_DATA_W   = 8;

	// default period counter width
	localparam int PERIOD_BITS_DEF = 16;

	// largest effective divider values
	localparam logic [PRESC_W-1:0] PRESC_MAX = PRESC_W'(65536);
	localparam logic [MSDIV_W-1:0] MSDIV_MAX = MSDIV_W'(16777216);

	// register reset values
	localparam logic [PRESC_W-1:0] PRESC_RST = PRESC_W'(1099);
	localparam logic [REF_W-1:0]   REF_RST   = REF_W'(65573);
	localparam logic [MSDIV_W-1:0] MSDIV_RST = MSDIV_W'(72000);

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_PRESCALE_DIV    = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_REFERENCE_COUNT = CFG_ADDR_W'(1);
	localparam logic [CFG_ADDR_W-1:0] REG_MS_DIV          = CFG_ADDR_W'(2);

	// input item kinds
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// command toward the timer
	typedef struct packed {
		logic             tick;
		logic             load;
		logic             run;
		logic [DUR_W-1:0] dur;
	} tmr_cmd_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DIV  = 2'b10
	} state_t;

endpackage

`default_nettype wire

>>> rtl/core/ptg_divider.sv
// Iterative restoring divider: reference count over frequency, one quotient bit per cycle.
// Depends on ptg_pkg.
`default_nettype none

module ptg_divider (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire [ptg_pkg::REF_W-1:0]      dividend,
	input  wire [ptg_pkg::FREQ_W-1:0]     divisor,
	output logic [ptg_pkg::REF_W-1:0]     quotient,
	output ptg_pkg::div_stat_t            stat
);

	localparam int CNT_W = $clog2(ptg_pkg::REF_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [ptg_pkg::FREQ_W-1:0]    rem_q;
	logic [ptg_pkg::FREQ_W-1:0]    dvs_q;
	logic [ptg_pkg::REF_W-1:0]     quo_q;
	logic [ptg_pkg::FREQ_W:0]      shifted;
	logic                          ge;
	logic [ptg_pkg::FREQ_W:0]      diff;

	// one shift, compare and subtract step
	always_comb begin
		shifted = {rem_q, quo_q[ptg_pkg::REF_W-1]};
		ge      = shifted >= {1'b0, dvs_q};
		diff    = shifted - {1'b0, dvs_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ptg_pkg::REF_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[ptg_pkg::FREQ_W-1:0] : shifted[ptg_pkg::FREQ_W-1:0];
			quo_q <= {quo_q[ptg_pkg::REF_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign stat     = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

>>> rtl/core/ptg_timer.sv
// Tone timer: millisecond divider, remaining time, prescaler and period counter.
// Depends on ptg_pkg; gives the output levels for the state after each update.
`default_nettype none

module ptg_timer #(
	parameter int PERIOD_BITS = ptg_pkg::PERIOD_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  ptg_pkg::tmr_cmd_t               cmd,
	input  wire [PERIOD_BITS-1:0]           load_period,
	input  wire [ptg_pkg::PRESC_W-1:0]      prescale_div,
	input  wire [ptg_pkg::MSDIV_W-1:0]      ms_div,
	output logic                            pwm_next,
	output logic                            playing_next
);

	logic [ptg_pkg::PCNT_W-1:0]  psc_q, psc_d;
	logic [PERIOD_BITS-1:0]      pcnt_q, pcnt_d;
	logic [PERIOD_BITS-1:0]      pval_q, pval_d;
	logic [PERIOD_BITS-1:0]      cmp_q, cmp_d;
	logic [ptg_pkg::MSCNT_W-1:0] ms_q, ms_d;
	logic [ptg_pkg::DUR_W-1:0]   rem_q, rem_d;
	logic                        run_q, run_d;
	logic [ptg_pkg::PRESC_W-1:0] pd_eff;
	logic [ptg_pkg::MSDIV_W-1:0] md_eff;

	// dividers above their range act as the range limit
	always_comb begin
		pd_eff = (prescale_div > ptg_pkg::PRESC_MAX) ? ptg_pkg::PRESC_MAX : prescale_div;
		md_eff = (ms_div > ptg_pkg::MSDIV_MAX) ? ptg_pkg::MSDIV_MAX : ms_div;
	end

	// next state
	always_comb begin
		psc_d  = psc_q;
		pcnt_d = pcnt_q;
		pval_d = pval_q;
		cmp_d  = cmp_q;
		ms_d   = ms_q;
		rem_d  = rem_q;
		run_d  = run_q;
		if (cmd.load) begin
			pval_d = load_period;
			cmp_d  = load_period >> 1;
			psc_d  = '0;
			pcnt_d = '0;
			rem_d  = cmd.dur;
			run_d  = cmd.run;
		end else if (cmd.tick) begin
			// millisecond divider and remaining time
			if (({1'b0, ms_q} + ptg_pkg::MSDIV_W'(1)) >= md_eff) begin
				ms_d = '0;
				if (rem_q != '0) begin
					rem_d = rem_q - ptg_pkg::DUR_W'(1);
					if (rem_q == ptg_pkg::DUR_W'(1)) begin
						run_d = 1'b0;
					end
				end
			end else begin
				ms_d = ms_q + ptg_pkg::MSCNT_W'(1);
			end
			// prescaler and period counter
			if (run_d) begin
				if (({1'b0, psc_q} + ptg_pkg::PRESC_W'(1)) >= pd_eff) begin
					psc_d = '0;
					if (({1'b0, pcnt_q} + (PERIOD_BITS+1)'(1)) >= {1'b0, pval_q}) begin
						pcnt_d = '0;
					end else begin
						pcnt_d = pcnt_q + PERIOD_BITS'(1);
					end
				end else begin
					psc_d = psc_q + ptg_pkg::PCNT_W'(1);
				end
			end
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psc_q  <= '0;
			pcnt_q <= '0;
			pval_q <= '0;
			cmp_q  <= '0;
			ms_q   <= '0;
			rem_q  <= '0;
			run_q  <= 1'b0;
		end else begin
			psc_q  <= psc_d;
			pcnt_q <= pcnt_d;
			pval_q <= pval_d;
			cmp_q  <= cmp_d;
			ms_q   <= ms_d;
			rem_q  <= rem_d;
			run_q  <= run_d;
		end
	end

	// output levels after this update
	assign pwm_next     = run_d && (pcnt_d < cmp_d);
	assign playing_next = rem_d != '0;

endmodule

`default_nettype wire

>>> rtl/core/pwm_tone_generator_with_duration_top.sv
// Top level of the PWM tone generator with duration: stream ports, registers, sequencer.
// Depends on ptg_pkg, ptg_divider and ptg_timer.
`default_nettype none

// A tick transaction (tuser 0) is one input clock of the tone timer; its result transaction
// carries the pwm level and the playing flag after the tick. A start transaction (tuser 1)
// computes period = reference_count / frequency on a shared restoring divider, one quotient
// bit per cycle over 24 divider steps, and the timer is loaded once the divider is done; a
// start with frequency 0 means silence and skips the divider. One transaction is in work
// at a time, and a new one is taken once the output register is empty or is being read in
// the same cycle. Period is saturated to PERIOD_BITS bits and the compare value is half
// of it.

module pwm_tone_generator_with_duration_top #(
	parameter int PERIOD_BITS = ptg_pkg::PERIOD_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// configuration writes
	input  wire                              cfg_we,
	input  wire [ptg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire [ptg_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input stream
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire [ptg_pkg::S_DATA_W-1:0]      s_axis_tdata,  // frequency[15:0], duration_ms[31:16]
	input  wire                              s_axis_tuser,  // op
	// output stream
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [ptg_pkg::M_DATA_W-1:0]     m_axis_tdata   // pwm_out[0], playing[1], zeros
);

	localparam int WW = (PERIOD_BITS > ptg_pkg::REF_W) ? PERIOD_BITS : ptg_pkg::REF_W;
	localparam logic [WW-1:0] PMAX_WIDE = WW'({PERIOD_BITS{1'b1}});

	logic [ptg_pkg::PRESC_W-1:0]  presc_q;
	logic [ptg_pkg::REF_W-1:0]    ref_q;
	logic [ptg_pkg::MSDIV_W-1:0]  msdiv_q;
	ptg_pkg::state_t              state_q;
	logic [ptg_pkg::DUR_W-1:0]    dur_q;
	logic                         out_vld_q;
	logic                         pwm_q;
	logic                         play_q;

	logic                         s_acc;
	logic [ptg_pkg::FREQ_W-1:0]   in_freq;
	logic [ptg_pkg::DUR_W-1:0]    in_dur;
	logic                         div_start;
	logic [ptg_pkg::REF_W-1:0]    quotient;
	ptg_pkg::div_stat_t           div_stat;
	logic [WW-1:0]                q_wide;
	logic [PERIOD_BITS-1:0]       period_sat;
	logic [PERIOD_BITS-1:0]       load_period;
	ptg_pkg::tmr_cmd_t            cmd;
	logic                         pwm_next;
	logic                         playing_next;
	logic                         result_en;

	assign in_freq = s_axis_tdata[ptg_pkg::FREQ_W-1:0];
	assign in_dur  = s_axis_tdata[ptg_pkg::FREQ_W +: ptg_pkg::DUR_W];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q <= ptg_pkg::PRESC_RST;
			ref_q   <= ptg_pkg::REF_RST;
			msdiv_q <= ptg_pkg::MSDIV_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ptg_pkg::REG_PRESCALE_DIV:    presc_q <= cfg_data[ptg_pkg::PRESC_W-1:0];
				ptg_pkg::REG_REFERENCE_COUNT: ref_q   <= cfg_data[ptg_pkg::REF_W-1:0];
				ptg_pkg::REG_MS_DIV:          msdiv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake
	assign s_axis_tready = (state_q == ptg_pkg::ST_IDLE) && (!out_vld_q || m_axis_tready);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign div_start     = s_acc && (s_axis_tuser == ptg_pkg::OP_START) && (in_freq != '0);

	// shared divider
	ptg_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ref_q),
		.divisor  (in_freq),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// saturate the quotient to the period width
	always_comb begin
		q_wide     = WW'(quotient);
		period_sat = (q_wide > PMAX_WIDE) ? {PERIOD_BITS{1'b1}} : PERIOD_BITS'(q_wide);
	end

	// timer command from the sequencer
	always_comb begin
		cmd         = '0;
		load_period = '0;
		unique case (state_q)
			ptg_pkg::ST_IDLE: begin
				if (s_acc) begin
					if (s_axis_tuser == ptg_pkg::OP_TICK) begin
						cmd.tick = 1'b1;
					end else if (in_freq == '0) begin
						cmd.load = 1'b1;
						cmd.run  = 1'b0;
						cmd.dur  = in_dur;
					end
				end
			end
			ptg_pkg::ST_DIV: begin
				if (div_stat.done) begin
					cmd.load    = 1'b1;
					cmd.run     = 1'b1;
					cmd.dur     = dur_q;
					load_period = period_sat;
				end
			end
			default: ;
		endcase
	end

	assign result_en = cmd.tick || cmd.load;

	// tone timer
	ptg_timer #(
		.PERIOD_BITS (PERIOD_BITS)
	) u_tmr (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.load_period  (load_period),
		.prescale_div (presc_q),
		.ms_div       (msdiv_q),
		.pwm_next     (pwm_next),
		.playing_next (playing_next)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptg_pkg::ST_IDLE;
		end else begin
			unique case (state_q)
				ptg_pkg::ST_IDLE: begin
					if (div_start) begin
						state_q <= ptg_pkg::ST_DIV;
					end
				end
				ptg_pkg::ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ptg_pkg::ST_IDLE;
					end
				end
				default: state_q <= ptg_pkg::ST_IDLE;
			endcase
		end
	end

	// duration held while dividing
	always_ff @(posedge clk) begin
		if (div_start) begin
			dur_q <= in_dur;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (result_en) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_en) begin
			pwm_q  <= pwm_next;
			play_q <= playing_next;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {{(ptg_pkg::M_DATA_W-2){1'b0}}, play_q, pwm_q};

endmodule

`default_nettype wire

>>> tb/sv/tb_pwm_tone_generator_with_duration_top.sv
// Self-checking testbench for pwm_tone_generator_with_duration_top: directed table, then random
// phases over several register settings and idle patterns, results checked by table or predictor.
// Depends on ptg_pkg and the top level of the tone generator.

module tb_pwm_tone_generator_with_duration_top;
	import ptg_pkg::*;

	// one result transaction, as packed in m_axis_tdata
	typedef struct packed {
		logic playing;
		logic pwm;
	} tone_out_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic                  op;
		logic [FREQ_W-1:0]     freq;
		logic [DUR_W-1:0]      dur;
		logic [CFG_ADDR_W-1:0] idx;
		logic [CFG_DATA_W-1:0] val;
		logic                  typed;
		tone_out_t             res;
	} stim_row_t;

	localparam int N_ROWS      = 30;
	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 116;
	localparam int HOLD_CYCLES = 400;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_axis_tdata;

	// predictor registers and state
	logic [PRESC_W-1:0] cfg_presc_div = PRESC_RST;
	logic [REF_W-1:0]   cfg_ref_count = REF_RST;
	logic [MSDIV_W-1:0] cfg_ms_div    = MSDIV_RST;
	logic [15:0]        pre_cnt       = '0;
	logic [PCNT_W-1:0]  per_cnt       = '0;
	logic [PCNT_W-1:0]  per_len       = '0;
	logic [PCNT_W-1:0]  per_cmp       = '0;
	logic [MSCNT_W-1:0] ms_cnt        = '0;
	logic [DUR_W-1:0]   ms_left       = '0;
	logic               tone_on       = 1'b0;

	tone_out_t tone_expect_q[$];
	int        n_fail      = 0;
	int        tx_idle_pct = 0;
	int        rx_stall_pct = 0;
	bit        hold_req    = 1'b0;
	int        hold_left   = 0;
	stim_row_t dir_rows [N_ROWS];

	pwm_tone_generator_with_duration_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// tone state after one tick or start
	function automatic tone_out_t tone_model_step(logic op, logic [FREQ_W-1:0] freq,
			logic [DUR_W-1:0] dur);
		logic [REF_W-1:0]   quo;
		logic [MSDIV_W-1:0] ms_lim;
		logic [PRESC_W-1:0] pre_lim;
		tone_out_t          res;
		if (op == OP_START) begin
			quo = '0;
			if (freq != '0)
				quo = cfg_ref_count / REF_W'(freq);
			per_len = (quo > REF_W'(16'hFFFF)) ? 16'hFFFF : quo[PCNT_W-1:0];
			per_cmp = per_len >> 1;
			pre_cnt = '0;
			per_cnt = '0;
			ms_left = dur;
			tone_on = (freq != '0);
		end else begin
			ms_lim  = (cfg_ms_div == '0) ? MSDIV_W'(1) :
				(cfg_ms_div > MSDIV_MAX) ? MSDIV_MAX : cfg_ms_div;
			pre_lim = (cfg_presc_div == '0) ? PRESC_W'(1) :
				(cfg_presc_div > PRESC_MAX) ? PRESC_MAX : cfg_presc_div;
			// millisecond divider and remaining time
			if ({1'b0, ms_cnt} + MSDIV_W'(1) >= ms_lim) begin
				ms_cnt = '0;
				if (ms_left != '0) begin
					ms_left = ms_left - 1'b1;
					if (ms_left == '0)
						tone_on = 1'b0;
				end
			end else begin
				ms_cnt = ms_cnt + 1'b1;
			end
			// prescaler and period counter
			if (tone_on) begin
				if ({1'b0, pre_cnt} + PRESC_W'(1) >= pre_lim) begin
					pre_cnt = '0;
					if ({1'b0, per_cnt} + 17'd1 >= {1'b0, per_len})
						per_cnt = '0;
					else
						per_cnt = per_cnt + 1'b1;
				end else begin
					pre_cnt = pre_cnt + 1'b1;
				end
			end
		end
		res.pwm     = tone_on && (per_cnt < per_cmp);
		res.playing = (ms_left != '0);
		return res;
	endfunction

	function automatic stim_row_t item_row(logic op, logic [FREQ_W-1:0] freq,
			logic [DUR_W-1:0] dur, logic typed, logic pwm, logic playing);
		stim_row_t r;
		r = '0;
		r.kind        = ROW_ITEM;
		r.op          = op;
		r.freq        = freq;
		r.dur         = dur;
		r.typed       = typed;
		r.res.pwm     = pwm;
		r.res.playing = playing;
		return r;
	endfunction

	function automatic stim_row_t reg_row(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		stim_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.idx  = idx;
		r.val  = val;
		return r;
	endfunction

	// offer one transaction, record its expected result on acceptance
	task automatic send_item(logic op, logic [FREQ_W-1:0] freq, logic [DUR_W-1:0] dur,
			logic typed, tone_out_t typed_res);
		tone_out_t pred;
		if ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {dur, freq};
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		pred = tone_model_step(op, freq, dur);
		tone_expect_q.push_back(typed ? typed_res : pred);
	endtask

	// register write once the block has drained
	task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		s_axis_tvalid <= 1'b0;
		while (tone_expect_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PRESCALE_DIV:    cfg_presc_div = val[PRESC_W-1:0];
			REG_REFERENCE_COUNT: cfg_ref_count = val[REF_W-1:0];
			REG_MS_DIV:          cfg_ms_div    = val[MSDIV_W-1:0];
			default: ;
		endcase
	endtask

	// register setting of each random phase, extremes included
	task automatic set_phase_regs(int ph);
		case (ph)
			0: begin
				write_reg(REG_PRESCALE_DIV, 25'd1);
				write_reg(REG_REFERENCE_COUNT, 25'd40);
				write_reg(REG_MS_DIV, 25'd3);
			end
			1: begin
				write_reg(REG_PRESCALE_DIV, 25'd2);
				write_reg(REG_REFERENCE_COUNT, 25'd100);
				write_reg(REG_MS_DIV, 25'd5);
			end
			2: begin
				write_reg(REG_PRESCALE_DIV, 25'd0);
				write_reg(REG_REFERENCE_COUNT, 25'hFFFFFF);
				write_reg(REG_MS_DIV, 25'd0);
			end
			3: begin
				write_reg(REG_PRESCALE_DIV, 25'd3);
				write_reg(REG_REFERENCE_COUNT, CFG_DATA_W'($urandom_range(300, 1)));
				write_reg(REG_MS_DIV, CFG_DATA_W'($urandom_range(10, 1)));
			end
			4: begin
				write_reg(REG_PRESCALE_DIV, 25'h10000);
				write_reg(REG_REFERENCE_COUNT, 25'd0);
				write_reg(REG_MS_DIV, 25'h1000000);
			end
			5: begin
				write_reg(REG_PRESCALE_DIV, 25'h1FFFF);
				write_reg(REG_REFERENCE_COUNT, CFG_DATA_W'($urandom_range(24'hFFFFFF, 0)));
				write_reg(REG_MS_DIV, 25'h1FFFFFF);
			end
			default: begin
				write_reg(REG_PRESCALE_DIV, CFG_DATA_W'($urandom_range(4, 1)));
				write_reg(REG_REFERENCE_COUNT, CFG_DATA_W'($urandom_range(500, 1)));
				write_reg(REG_MS_DIV, CFG_DATA_W'($urandom_range(12, 1)));
			end
		endcase
	endtask

	// result side: check each transaction, then pick the next ready level
	always @(posedge clk) begin
		tone_out_t got;
		tone_out_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[1:0];
			if (tone_expect_q.size() == 0) begin
				$error("result transaction with none expected: pwm_out %0d playing %0d",
					got.pwm, got.playing);
				n_fail++;
			end else begin
				want = tone_expect_q.pop_front();
				if (got.pwm !== want.pwm) begin
					$error("pwm_out: expected %0d, got %0d", want.pwm, got.pwm);
					n_fail++;
				end
				if (got.playing !== want.playing) begin
					$error("playing: expected %0d, got %0d", want.playing, got.playing);
					n_fail++;
				end
			end
		end
		// long hold-off while the sender keeps offering
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// stimulus
	initial begin
		int                ph;
		int                k;
		int                sel;
		logic [FREQ_W-1:0] f;
		logic [DUR_W-1:0]  d;

		// directed table, reset register values until the first write
		dir_rows = '{
			item_row(OP_TICK,  16'd0,      16'd0,      1'b1, 1'b0, 1'b0),
			item_row(OP_START, 16'd0,      16'hFFFF,   1'b1, 1'b0, 1'b1),
			item_row(OP_TICK,  16'd0,      16'd0,      1'b1, 1'b0, 1'b1),
			item_row(OP_START, 16'd1,      16'd0,      1'b1, 1'b1, 1'b0),
			item_row(OP_TICK,  16'hFFFF,   16'hFFFF,   1'b1, 1'b1, 1'b0),
			item_row(OP_START, 16'hFFFF,   16'd1,      1'b1, 1'b0, 1'b1),
			item_row(OP_TICK,  16'd0,      16'd0,      1'b0, 1'b0, 1'b0),
			reg_row(REG_REFERENCE_COUNT, 25'd0),
			item_row(OP_START, 16'd5,      16'd3,      1'b1, 1'b0, 1'b1),
			item_row(OP_TICK,  16'd0,      16'd0,      1'b0, 1'b0, 1'b0),
			reg_row(REG_PRESCALE_DIV, 25'd0),
			reg_row(REG_MS_DIV, 25'd0),
			item_row(OP_TICK,  16'd0,      16'd0,      1'b0, 1'b0, 1'b0),
			item_row(OP_TICK,  16'd0,      16'd0,      1'b0, 1'b0, 1'b0),
			item_row(OP_TICK,  16'd0,      16'd0,      1'b0, 1'b0, 1'b0),
			item_row(OP_TICK,  16'd0,      16'd0,      1'b0, 1'b0, 1'b0),
			reg_row(REG_REFERENCE_COUNT, 25'hFFFFFF),
			item_row(OP_START, 16'hFFFF,   16'd2,      1'b1, 1'b1, 1'b1),
			item_row(OP_TICK,  16'd0,      16'd0,      1'b0, 1'b0, 1'b0),
			item_row(OP_TICK,  16'd0,      16'd0,      1'b0, 1'b0, 1'b0),
			item_row(OP_TICK,  16'd0,      16'd0,      1'b0, 1'b0, 1'b0),
			reg_row(REG_PRESCALE_DIV, 25'h1FFFF),
			reg_row(REG_MS_DIV, 25'h1FFFFFF),
			item_row(OP_START, 16'd1,      16'hFFFF,   1'b1, 1'b1, 1'b1),
			item_row(OP_TICK,  16'd0,      16'd0,      1'b0, 1'b0, 1'b0),
			item_row(OP_TICK,  16'd0,      16'd0,      1'b0, 1'b0, 1'b0),
			reg_row(REG_PRESCALE_DIV, 25'h10000),
			reg_row(REG_MS_DIV, 25'h1000000),
			item_row(OP_START, 16'd2,      16'd0,      1'b1, 1'b1, 1'b0),
			item_row(OP_TICK,  16'd0,      16'd0,      1'b0, 1'b0, 1'b0)
		};

		// reset
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_REG)
				write_reg(dir_rows[i].idx, dir_rows[i].val);
			else
				send_item(dir_rows[i].op, dir_rows[i].freq, dir_rows[i].dur,
					dir_rows[i].typed, dir_rows[i].res);
		end

		// random phases: mostly ticks, a start now and then
		for (ph = 0; ph < N_PHASES; ph++) begin
			set_phase_regs(ph);
			case (ph % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
				default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
			endcase
			if (ph == 4) begin
				tx_idle_pct = 0;
				hold_req    = 1'b1;
			end
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(99) < 12) begin
					sel = $urandom_range(99);
					f = (sel < 10) ? 16'd0 : (sel < 25) ? FREQ_W'($urandom) :
						FREQ_W'($urandom_range(40, 1));
					sel = $urandom_range(99);
					d = (sel < 15) ? 16'd0 : (sel < 30) ? DUR_W'($urandom) :
						DUR_W'($urandom_range(30, 1));
					send_item(OP_START, f, d, 1'b0, '0);
				end else begin
					send_item(OP_TICK, FREQ_W'($urandom), DUR_W'($urandom), 1'b0, '0);
				end
			end
		end

		// drain and let any stray result show up
		s_axis_tvalid <= 1'b0;
		while (tone_expect_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (n_fail == 0)
			$display("[pwm_tone_generator_with_duration_top] OK");
		else
			$display("[pwm_tone_generator_with_duration_top] ERROR");
		$finish;
	end

	// run limit
	initial begin
		#6000000;
		$display("[pwm_tone_generator_with_duration_top] ERROR");
		$finish;
	end

endmodule
